@@ rtl/apc_pkg.sv @@
// apc_pkg: shared constants and types of the amicable pair checker
`timescale 1ns / 1ps

package apc_pkg;

    // width of one input field on the channel
    localparam int FIELD_WIDTH  = 16;
    // operand width used by the arithmetic; fields are cut or extended to it
    localparam int NUMBER_WIDTH = 16;
    // divisor sums of an operand stay below eight times the operand
    localparam int SUM_WIDTH    = NUMBER_WIDTH + 3;
    localparam int BIT_WIDTH    = $clog2(NUMBER_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_ACC,
        ST_DONE
    } state_t;

endpackage

@@ rtl/apc_if.sv @@
// apc_if: valid/ready channels for operand and result words
`timescale 1ns / 1ps

interface apc_in_if;
    logic                              valid;
    logic                              ready;
    logic [apc_pkg::FIELD_WIDTH-1:0]   first_number;
    logic [apc_pkg::FIELD_WIDTH-1:0]   second_number;

    modport source (output valid, output first_number, output second_number, input ready);
    modport sink   (input valid, input first_number, input second_number, output ready);
endinterface

interface apc_out_if;
    logic valid;
    logic ready;
    logic is_amicable;

    modport source (output valid, output is_amicable, input ready);
    modport sink   (input valid, input is_amicable, output ready);
endinterface

@@ rtl/amicable_pair_checker.sv @@
// amicable_pair_checker: tests two numbers for an amicable pair
//
// operands channel carries first_number and second_number; result channel
// returns one word with is_amicable per operand word, in order.
// one operand word is worked on at a time: ready is high only while the
// sequencer is idle. each operand n is scanned with trial divisors
// d = 1 .. n/2, every trial is a restoring remainder on one shared
// subtract/compare unit, one quotient bit per cycle.
// the second operand is scanned only when the first sum matches.
// a zero or repeated operand word skips the divisor scan and goes straight
// to the done state, which loads the output register; the next word can be
// taken once the sequencer is back in idle.
// the result sits in an output register; a new operand word is taken while
// it waits, but that word's result is held back until the old one is taken.
// reset (rst_n low, asynchronous) returns the sequencer to idle and drops
// any pending result.
`timescale 1ns / 1ps

module amicable_pair_checker (
    input  logic       clk,
    input  logic       rst_n,
    apc_in_if.sink     operands,
    apc_out_if.source  result
);

    localparam int NW = apc_pkg::NUMBER_WIDTH;
    localparam int SW = apc_pkg::SUM_WIDTH;
    localparam int BW = apc_pkg::BIT_WIDTH;

    apc_pkg::state_t state_reg, state_next;

    logic [NW-1:0] a_reg, a_next;
    logic [NW-1:0] b_reg, b_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] d_reg, d_next;
    logic [NW:0]   rem_reg, rem_next;
    logic [BW-1:0] bit_reg, bit_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic          sel_reg, sel_next;
    logic          res_reg, res_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_data_reg, out_data_next;

    logic          accept;
    logic [NW-1:0] in_a;
    logic [NW-1:0] in_b;
    logic [NW:0]   shifted;
    logic [NW:0]   diff;
    logic [SW-1:0] other;

    assign accept = operands.valid && operands.ready;
    assign in_a   = NW'(operands.first_number);
    assign in_b   = NW'(operands.second_number);

    // one restoring step of the remainder
    assign shifted = {rem_reg[NW-1:0], n_reg[bit_reg]};
    assign diff    = shifted - {1'b0, d_reg};

    assign other = sel_reg ? SW'(a_reg) : SW'(b_reg);

    assign operands.ready     = (state_reg == apc_pkg::ST_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.is_amicable = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= apc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        n_reg        <= n_next;
        d_reg        <= d_next;
        rem_reg      <= rem_next;
        bit_reg      <= bit_next;
        sum_reg      <= sum_next;
        sel_reg      <= sel_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        sum_next       = sum_reg;
        sel_next       = sel_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !result.ready;

        unique case (state_reg)
            apc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    a_next   = in_a;
                    b_next   = in_b;
                    n_next   = in_a;
                    d_next   = NW'(1);
                    sum_next = '0;
                    sel_next = 1'b0;
                    res_next = 1'b0;
                    if (in_a == '0 || in_b == '0 || in_a == in_b)
                    begin
                        state_next = apc_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = apc_pkg::ST_CHECK;
                    end
                end
            end

            apc_pkg::ST_CHECK:
            begin
                if (d_reg <= (n_reg >> 1))
                begin
                    rem_next   = '0;
                    bit_next   = BW'(NW - 1);
                    state_next = apc_pkg::ST_DIV;
                end
                else if (sum_reg != other)
                begin
                    res_next   = 1'b0;
                    state_next = apc_pkg::ST_DONE;
                end
                else if (!sel_reg)
                begin
                    // first sum matches, scan the second operand
                    sel_next = 1'b1;
                    n_next   = b_reg;
                    d_next   = NW'(1);
                    sum_next = '0;
                end
                else
                begin
                    res_next   = 1'b1;
                    state_next = apc_pkg::ST_DONE;
                end
            end

            apc_pkg::ST_DIV:
            begin
                rem_next = diff[NW] ? shifted : diff;
                bit_next = bit_reg - BW'(1);
                if (bit_reg == '0)
                begin
                    state_next = apc_pkg::ST_ACC;
                end
            end

            apc_pkg::ST_ACC:
            begin
                if (rem_reg == '0)
                begin
                    sum_next = sum_reg + SW'(d_reg);
                end
                d_next     = d_reg + NW'(1);
                state_next = apc_pkg::ST_CHECK;
            end

            apc_pkg::ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = apc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = apc_pkg::ST_IDLE;
            end
        endcase
    end

    // trivial operand words skip the divisor scan with a false result
    a_trivial_false: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_a == '0 || in_b == '0 || in_a == in_b))
        |=> (state_reg == apc_pkg::ST_DONE && !res_reg))
        else $error("trivial operands did not give a direct false");

    // remainder stays below the trial divisor through the division
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == apc_pkg::ST_DIV) |-> (rem_reg < {1'b0, d_reg}))
        else $error("remainder reached the divisor");

    // each finished trial moves to the next divisor
    a_divisor_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == apc_pkg::ST_ACC) |=> (d_reg == $past(d_reg) + NW'(1)))
        else $error("trial divisor did not advance");

    // a result word appears only when the sequencer finishes an item
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == apc_pkg::ST_DONE))
        else $error("result word raised outside completion");

    // a true result needs both operand scans
    a_true_needs_second: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == apc_pkg::ST_DONE && res_reg) |-> sel_reg)
        else $error("true result without second scan");

endmodule
